/* design/rdge_pkg.sv */
package rdge_pkg;

   // Default width of the signed input value.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Configuration register geometry.
   localparam int RADIX_WIDTH      = 5;
   localparam int GROUP_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIX         = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GROUP_DIVISOR = 1'd1;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
   localparam logic [GROUP_WIDTH-1:0] GROUP_RESET = 16'd1000;

   // Smallest and largest usable radix.
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

   // Result field widths.
   localparam int DIGIT_WIDTH  = 4;
   localparam int GROUP_INDEX_WIDTH = 5;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RADIX_ZERO  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_GROUP_ZERO  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_POWER   = 2'd3;

   // Results per input are capped at this count.
   localparam int MAX_RESULTS = 32;

   // Quotient bits resolved per divider cycle.
   localparam int DIV_BITS = 8;

   // Running power of the radix; stays below group divisor times radix.
   localparam int RATE_WIDTH = 20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic check_step;
      logic div_init;
      logic div_step;
      logic load_out;
      logic out_error;
   } rdge_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] check_code;
      logic                    check_done;
      logic                    div_last;
      logic                    last_digit;
      logic                    out_free;
   } rdge_status_type;

endpackage

/* design/rdge_datapath.sv */
module rdge_datapath import rdge_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rdge_cmd_type                  cmd,
   output rdge_status_type               status,
   input  logic [RADIX_WIDTH-1:0]        radix,
   input  logic [GROUP_WIDTH-1:0]        group_divisor,
   input  logic signed [VALUE_WIDTH-1:0] req_signed_value,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [DIGIT_WIDTH-1:0]        rsp_digit,
   output logic [GROUP_INDEX_WIDTH-1:0]  rsp_group_index,
   output logic                          rsp_negative,
   output logic [STATUS_WIDTH-1:0]       rsp_status,
   output logic                          rsp_last
);

   localparam int PadWidth   = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int DivCycles  = PadWidth / DIV_BITS;
   localparam int CountWidth = $clog2(DivCycles + 1);

   logic [PadWidth-1:0]          work_ff, work_in;
   logic [DIGIT_WIDTH-1:0]       rem_ff, rem_in;
   logic [CountWidth-1:0]        cnt_ff, cnt_in;
   logic [RATE_WIDTH-1:0]        rate_ff, rate_in;
   logic [COUNT_WIDTH-1:0]       k_ff, k_in;
   logic [COUNT_WIDTH-1:0]       dig_ff, dig_in;
   logic [GROUP_INDEX_WIDTH-1:0] grp_ff, grp_in;
   logic [COUNT_WIDTH-1:0]       n_ff, n_in;
   logic                         neg_ff, neg_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_WIDTH-1:0]       rsp_digit_ff, rsp_digit_in;
   logic [GROUP_INDEX_WIDTH-1:0] rsp_group_ff, rsp_group_in;
   logic                         rsp_negative_ff, rsp_negative_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff, rsp_status_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0]       value_bits;
   logic [VALUE_WIDTH-1:0]       magnitude;
   logic [DIV_BITS-1:0]          step_quot;
   logic [DIGIT_WIDTH-1:0]       step_rem;
   logic [STATUS_WIDTH-1:0]      check_code;
   logic [COUNT_WIDTH-1:0]       dig_next;

   // Magnitude of the incoming value; the most negative value maps to 2^(W-1).
   assign value_bits = req_signed_value;
   assign magnitude  = value_bits[VALUE_WIDTH-1] ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;

   // Configuration check, in priority order of the error codes.
   always_comb begin
      priority if (radix == '0) begin
         check_code = STATUS_RADIX_ZERO;
      end else if (group_divisor == '0) begin
         check_code = STATUS_GROUP_ZERO;
      end else if (radix < RADIX_MIN || radix > RADIX_MAX) begin
         check_code = STATUS_NOT_POWER;
      end else if (rate_ff > RATE_WIDTH'(group_divisor)) begin
         check_code = STATUS_NOT_POWER;
      end else begin
         check_code = STATUS_OK;
      end
   end

   // One divider cycle: restoring division of the top bits by the radix.
   always_comb begin
      logic [DIGIT_WIDTH-1:0] part_rem;
      logic [DIGIT_WIDTH:0]   trial;
      part_rem  = rem_ff;
      step_quot = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {part_rem, work_ff[PadWidth-1-i]};
         if (trial >= radix) begin
            step_quot[DIV_BITS-1-i] = 1'b1;
            trial = trial - radix;
         end
         part_rem = trial[DIGIT_WIDTH-1:0];
      end
      step_rem = part_rem;
   end

   assign dig_next = dig_ff + COUNT_WIDTH'(1);

   // Status toward the controller.
   always_comb begin
      status.check_code = check_code;
      status.check_done = (rate_ff == RATE_WIDTH'(group_divisor));
      status.div_last   = (cnt_ff == CountWidth'(1));
      status.last_digit = (work_ff == '0) || (n_ff == COUNT_WIDTH'(MAX_RESULTS - 1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Next values of the working registers.
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      rate_in = rate_ff;
      k_in    = k_ff;
      dig_in  = dig_ff;
      grp_in  = grp_ff;
      n_in    = n_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         work_in = PadWidth'(magnitude);
         neg_in  = value_bits[VALUE_WIDTH-1];
         rate_in = RATE_WIDTH'(radix);
         k_in    = COUNT_WIDTH'(1);
         dig_in  = '0;
         grp_in  = '0;
         n_in    = '0;
      end
      if (cmd.check_step) begin
         rate_in = RATE_WIDTH'(rate_ff * radix);
         k_in    = k_ff + COUNT_WIDTH'(1);
      end
      if (cmd.div_init) begin
         cnt_in = CountWidth'(DivCycles);
         rem_in = '0;
      end
      if (cmd.div_step) begin
         work_in = (work_ff << DIV_BITS) | PadWidth'(step_quot);
         rem_in  = step_rem;
         cnt_in  = cnt_ff - CountWidth'(1);
      end
      // Advance the digit and group counters when a digit goes out.
      if (cmd.load_out && !cmd.out_error) begin
         n_in = n_ff + COUNT_WIDTH'(1);
         if (dig_next == k_ff) begin
            dig_in = '0;
            grp_in = grp_ff + GROUP_INDEX_WIDTH'(1);
         end else begin
            dig_in = dig_next;
         end
      end
   end

   // Output register: holds a beat until the receiver takes it.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_digit_in    = rsp_digit_ff;
      rsp_group_in    = rsp_group_ff;
      rsp_negative_in = rsp_negative_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         if (cmd.out_error) begin
            rsp_digit_in    = '0;
            rsp_group_in    = '0;
            rsp_negative_in = 1'b0;
            rsp_status_in   = check_code;
            rsp_last_in     = 1'b1;
         end else begin
            rsp_digit_in    = rem_ff;
            rsp_group_in    = grp_ff;
            rsp_negative_in = neg_ff;
            rsp_status_in   = STATUS_OK;
            rsp_last_in     = status.last_digit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff         <= work_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      rate_ff         <= rate_in;
      k_ff            <= k_in;
      dig_ff          <= dig_in;
      grp_ff          <= grp_in;
      n_ff            <= n_in;
      neg_ff          <= neg_in;
      rsp_digit_ff    <= rsp_digit_in;
      rsp_group_ff    <= rsp_group_in;
      rsp_negative_ff <= rsp_negative_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit       = rsp_digit_ff;
   assign rsp_group_index = rsp_group_ff;
   assign rsp_negative    = rsp_negative_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* design/rdge_ctrl.sv */
module rdge_ctrl import rdge_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rdge_status_type status,
   output rdge_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SEND,
      ST_SEND_ERR
   } state_type;

   state_type state_ff, state_in;

   // New items are taken only between conversions.
   assign req_stall = (state_ff != ST_IDLE);

   // Sequencing and commands toward the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.check_code != STATUS_OK) begin
               state_in = ST_SEND_ERR;
            end else if (status.check_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end else begin
               cmd.check_step = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = ST_DIVIDE;
               end
            end
         end
         ST_SEND_ERR: begin
            if (status.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_error = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/radix_digit_group_extractor_top.sv */
// Radix digit group extractor.
// A signed value arrives as one beat on the req_ channel and leaves as one
// rsp_ beat per digit in the configured radix, least significant digit
// first, each with its group index and the sign of the value. The final beat
// of a value carries rsp_last. A zero value gives one zero digit; an unusable
// configuration gives one error beat with rsp_status set.
// Radix and group divisor are written through the csr_ port; they must be
// written only while idle, which the block itself does not enforce. After
// acceptance the configuration check multiplies a running power of the
// radix until it equals the group divisor, which gives the number of
// digits per group; an unusable configuration ends the check early. Each
// digit is then found by the shared digit divider, which resolves 8
// quotient bits a cycle, and is loaded into the output register.
// While the receiver stalls, the current beat holds in the output register
// and conversion pauses; the next value is accepted as soon as the last beat
// of the previous one is loaded. Synchronous reset returns the registers to
// radix 10 and group divisor 1000 and drops any beat in flight.
module radix_digit_group_extractor_top import rdge_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_signed_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIGIT_WIDTH-1:0]        rsp_digit,
   output logic [GROUP_INDEX_WIDTH-1:0]  rsp_group_index,
   output logic                          rsp_negative,
   output logic [STATUS_WIDTH-1:0]       rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_write_data
);

   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [GROUP_WIDTH-1:0] group_divisor_ff, group_divisor_in;
   rdge_cmd_type           cmd;
   rdge_status_type        status;

   // Configuration registers.
   always_comb begin
      radix_in         = radix_ff;
      group_divisor_in = group_divisor_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_RADIX:         radix_in = csr_write_data[RADIX_WIDTH-1:0];
            REG_GROUP_DIVISOR: group_divisor_in = csr_write_data[GROUP_WIDTH-1:0];
            default: begin
               radix_in         = radix_ff;
               group_divisor_in = group_divisor_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff         <= RADIX_RESET;
         group_divisor_ff <= GROUP_RESET;
      end else begin
         radix_ff         <= radix_in;
         group_divisor_ff <= group_divisor_in;
      end
   end

   rdge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdge_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .radix            (radix_ff),
      .group_divisor    (group_divisor_ff),
      .req_signed_value (req_signed_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_digit        (rsp_digit),
      .rsp_group_index  (rsp_group_index),
      .rsp_negative     (rsp_negative),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
